// ===== rtl/ndce_pkg.sv =====
package ndce_pkg;

    // Field widths
    localparam int NUM_W  = 14;
    localparam int CC_W   = 7;
    localparam int CHAN_W = 5;

    // Reset channel
    localparam logic [CHAN_W-1:0] CHAN_RESET = 5'd1;

    // Controller numbers of the four beats of one NRPN
    localparam logic [CC_W-1:0] CC_NUM_MSB = 7'd99;
    localparam logic [CC_W-1:0] CC_NUM_LSB = 7'd98;
    localparam logic [CC_W-1:0] CC_VAL_MSB = 7'd6;
    localparam logic [CC_W-1:0] CC_VAL_LSB = 7'd38;

    // Beat positions inside one message
    localparam logic [1:0] BEAT_NUM_MSB = 2'd0;
    localparam logic [1:0] BEAT_NUM_LSB = 2'd1;
    localparam logic [1:0] BEAT_VAL_MSB = 2'd2;
    localparam logic [1:0] BEAT_VAL_LSB = 2'd3;

    // Command codes
    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    // Number range to slot map: slot = number - offset
    typedef struct packed {
        logic [NUM_W-1:0] lo;
        logic [NUM_W-1:0] hi;
        logic [NUM_W-1:0] offset;
    } range_t;

    localparam int RANGE_COUNT = 10;

    localparam range_t SLOT_RANGES [RANGE_COUNT] = '{
        '{lo: 14'd100,  hi: 14'd114,  offset: 14'd100},
        '{lo: 14'd200,  hi: 14'd209,  offset: 14'd185},
        '{lo: 14'd220,  hi: 14'd232,  offset: 14'd195},
        '{lo: 14'd300,  hi: 14'd303,  offset: 14'd262},
        '{lo: 14'd500,  hi: 14'd502,  offset: 14'd458},
        '{lo: 14'd1000, hi: 14'd1002, offset: 14'd955},
        '{lo: 14'd2000, hi: 14'd2009, offset: 14'd1952},
        '{lo: 14'd3000, hi: 14'd3009, offset: 14'd2942},
        '{lo: 14'd4000, hi: 14'd4009, offset: 14'd3932},
        '{lo: 14'd5000, hi: 14'd5009, offset: 14'd4922}
    };

    // Load request from the controller to the beat serializer
    typedef struct packed {
        logic              load;
        logic [NUM_W-1:0]  number;
        logic [NUM_W-1:0]  value;
        logic [CHAN_W-1:0] channel;
    } tx_req_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_CHECK
    } state_t;

endpackage

// ===== rtl/ndce_ram.sv =====
module ndce_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 88
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ndce_slot_map.sv =====
module ndce_slot_map #(
    parameter int SLOT_COUNT = 88
) (
    input  logic [ndce_pkg::NUM_W-1:0]      number,
    output logic                            hit,
    output logic [$clog2(SLOT_COUNT)-1:0]   slot
);

    import ndce_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    logic [NUM_W-1:0] diff [RANGE_COUNT];
    logic [RANGE_COUNT-1:0] match;

    // Ranges are disjoint, so the per-range results can be OR-combined
    always_comb
    begin
        hit  = 1'b0;
        slot = '0;
        for (int r = 0; r < RANGE_COUNT; r++)
        begin
            diff[r]  = number - SLOT_RANGES[r].offset;
            match[r] = (number >= SLOT_RANGES[r].lo) && (number <= SLOT_RANGES[r].hi)
                       && (diff[r] < NUM_W'(SLOT_COUNT));
            if (match[r])
            begin
                hit  = 1'b1;
                slot = slot | diff[r][SLOT_W-1:0];
            end
        end
    end

endmodule

// ===== rtl/ndce_cc_tx.sv =====
module ndce_cc_tx (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ndce_pkg::tx_req_t           req,
    output logic                        busy,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ndce_pkg::CC_W-1:0]   cc_number,
    output logic [ndce_pkg::CC_W-1:0]   cc_value,
    output logic [ndce_pkg::CHAN_W-1:0] channel,
    output logic                        last_of_run
);

    import ndce_pkg::*;

    logic              busy_reg;
    logic [1:0]        beat_reg;
    logic [NUM_W-1:0]  number_reg;
    logic [NUM_W-1:0]  value_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic              beat_done;

    assign beat_done = busy_reg && !out_stall;

    // Beat sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= BEAT_NUM_MSB;
        end
        else if (req.load && !busy_reg)
        begin
            busy_reg <= 1'b1;
            beat_reg <= BEAT_NUM_MSB;
        end
        else if (beat_done)
        begin
            if (beat_reg == BEAT_VAL_LSB)
            begin
                busy_reg <= 1'b0;
            end
            beat_reg <= beat_reg + 2'd1;
        end
    end

    // Message payload, held for all four beats
    always_ff @(posedge clk)
    begin
        if (req.load && !busy_reg)
        begin
            number_reg <= req.number;
            value_reg  <= req.value;
            chan_reg   <= req.channel;
        end
    end

    // Beat payload select
    always_comb
    begin
        case (beat_reg)
            BEAT_NUM_MSB:
            begin
                cc_number = CC_NUM_MSB;
                cc_value  = number_reg[NUM_W-1:CC_W];
            end
            BEAT_NUM_LSB:
            begin
                cc_number = CC_NUM_LSB;
                cc_value  = number_reg[CC_W-1:0];
            end
            BEAT_VAL_MSB:
            begin
                cc_number = CC_VAL_MSB;
                cc_value  = value_reg[NUM_W-1:CC_W];
            end
            default:
            begin
                cc_number = CC_VAL_LSB;
                cc_value  = value_reg[CC_W-1:0];
            end
        endcase
    end

    assign busy        = busy_reg;
    assign out_valid   = busy_reg;
    assign channel     = chan_reg;
    assign last_of_run = busy_reg && (beat_reg == BEAT_VAL_LSB);

endmodule

// ===== rtl/nrpn_dedup_cc_encoder.sv =====
// An accepted item is registered with its slot lookup and checked in ST_CHECK, where a send
// loads the serializer once it is free; the serializer's busy register then starts the beats.
// The input stalls outside ST_IDLE, so items go one at a time; a send waits in ST_CHECK for the
// serializer to finish the four beats of the one before, more under stall. The slot table is a
// one-read one-write RAM with a registered read. Reset clears all slot valid flops at once
// (no clearing pass) and sets the channel register to 1; RAM contents are not reset.
module nrpn_dedup_cc_encoder #(
    parameter int SLOT_COUNT = 88
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ndce_pkg::CHAN_W-1:0] cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        cmd,
    input  logic [ndce_pkg::NUM_W-1:0]  param_number,
    input  logic [ndce_pkg::NUM_W-1:0]  param_value,
    input  logic                        sysex_busy,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ndce_pkg::CC_W-1:0]   cc_number,
    output logic [ndce_pkg::CC_W-1:0]   cc_value,
    output logic [ndce_pkg::CHAN_W-1:0] channel,
    output logic                        last_of_run
);

    import ndce_pkg::*;

    localparam int SLOT_W = $clog2(SLOT_COUNT);

    state_t            state_reg;
    state_t            state_next;
    logic [CHAN_W-1:0] chan_reg;
    logic [SLOT_COUNT-1:0] valid_reg;

    logic              cmd_reg;
    logic              sysex_reg;
    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [NUM_W-1:0]  number_reg;
    logic [NUM_W-1:0]  value_reg;

    logic              in_hit;
    logic [SLOT_W-1:0] in_slot;
    logic              accept;
    logic [SLOT_W-1:0] rd_addr;
    logic [NUM_W-1:0]  rd_data;
    logic              same;
    logic              emit;
    logic              done;
    logic              mem_we;
    logic              tx_busy;
    tx_req_t           tx_req;

    assign accept = in_valid && !in_stall;

    // Number to slot lookup on the input beat
    ndce_slot_map #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_map (
        .number (param_number),
        .hit    (in_hit),
        .slot   (in_slot)
    );

    // Slot value table: read on accept, write back in the check cycle
    assign rd_addr = (state_reg == ST_IDLE) ? in_slot : slot_reg;

    ndce_ram #(
        .WIDTH (NUM_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (slot_reg),
        .wdata (value_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Captured item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            sysex_reg  <= sysex_busy;
            hit_reg    <= in_hit;
            slot_reg   <= in_slot;
            number_reg <= param_number;
            value_reg  <= param_value;
        end
    end

    // Channel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_reg <= CHAN_RESET;
        end
        else if (cfg_we)
        begin
            chan_reg <= cfg_wdata;
        end
    end

    // Slot valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (mem_we)
        begin
            valid_reg[slot_reg] <= 1'b1;
        end
    end

    // Decision in the check cycle
    assign same = hit_reg && valid_reg[slot_reg] && (rd_data == value_reg);
    assign emit = (cmd_reg == CMD_SEND) && !sysex_reg && !same;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = accept ? ST_CHECK : ST_IDLE;
            ST_CHECK: state_next = done ? ST_IDLE : ST_CHECK;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb
    begin
        in_stall       = 1'b1;
        done           = 1'b0;
        mem_we         = 1'b0;
        tx_req.load    = 1'b0;
        tx_req.number  = number_reg;
        tx_req.value   = value_reg;
        tx_req.channel = chan_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_CHECK:
            begin
                // wait for the serializer before committing a send
                done        = !emit || !tx_busy;
                tx_req.load = emit && !tx_busy;
                mem_we      = done && hit_reg
                              && ((cmd_reg == CMD_RECV) || (!sysex_reg && !same));
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // Four-beat control change serializer
    ndce_cc_tx u_cc_tx (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (tx_req),
        .busy        (tx_busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cc_number   (cc_number),
        .cc_value    (cc_value),
        .channel     (channel),
        .last_of_run (last_of_run)
    );

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        tx_req.load |-> !tx_busy)
        else $error("serializer loaded while busy");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_CHECK))
        else $error("accepted item not checked next cycle");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_run && !out_stall) |=> !out_valid)
        else $error("beat after last of run");

    a_write_check: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_CHECK) && hit_reg))
        else $error("table write outside check of a mapped slot");
`endif

endmodule

// ===== sim/tb_nrpn_dedup_cc_encoder.sv =====
module tb_nrpn_dedup_cc_encoder;

    import ndce_pkg::*;

    localparam int SLOTS       = 88;
    localparam int CYCLE_LIMIT = 200000;
    localparam int QUIET       = 8;
    localparam int MAX_IDLE    = 18;

    typedef struct packed {
        logic             cmd;
        logic [NUM_W-1:0] number;
        logic [NUM_W-1:0] value;
        logic             busy;
    } nrpn_item_t;

    typedef struct packed {
        logic [CC_W-1:0]   num;
        logic [CC_W-1:0]   val;
        logic [CHAN_W-1:0] chan;
        logic              last;
    } cc_beat_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CHAN_W-1:0] cfg_wdata = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              cmd = CMD_SEND;
    logic [NUM_W-1:0]  param_number = '0;
    logic [NUM_W-1:0]  param_value = '0;
    logic              sysex_busy = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [CC_W-1:0]   cc_number;
    logic [CC_W-1:0]   cc_value;
    logic [CHAN_W-1:0] channel;
    logic              last_of_run;

    // Predictor state: slot cache and current output channel
    bit                slot_full [SLOTS];
    bit [NUM_W-1:0]    slot_value [SLOTS];
    logic [CHAN_W-1:0] chan_now = CHAN_RESET;

    nrpn_item_t nrpn_pending [$];
    cc_beat_t   cc_expected [$];
    nrpn_item_t in_item;

    int in_gap = 0;
    int out_hold = 0;
    int in_gap_max = 0;
    int out_stall_max = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    nrpn_dedup_cc_encoder #(.SLOT_COUNT(SLOTS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .param_number (param_number),
        .param_value  (param_value),
        .sysex_busy   (sysex_busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cc_number    (cc_number),
        .cc_value     (cc_value),
        .channel      (channel),
        .last_of_run  (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Number to cache slot, -1 when the number falls in no range
    function automatic int slot_of_number(input logic [NUM_W-1:0] n);
        int s;
        s = -1;
        if (n >= 100 && n <= 114)        s = n - 100;
        else if (n >= 200 && n <= 209)   s = n - 185;
        else if (n >= 220 && n <= 232)   s = n - 195;
        else if (n >= 300 && n <= 303)   s = n - 262;
        else if (n >= 500 && n <= 502)   s = n - 458;
        else if (n >= 1000 && n <= 1002) s = n - 955;
        else if (n >= 2000 && n <= 2009) s = n - 1952;
        else if (n >= 3000 && n <= 3009) s = n - 2942;
        else if (n >= 4000 && n <= 4009) s = n - 3932;
        else if (n >= 5000 && n <= 5009) s = n - 4922;
        return s;
    endfunction

    // Inverse map, used to aim random traffic at cached slots
    function automatic logic [NUM_W-1:0] number_of_slot(input int s);
        int n;
        if (s < 15)      n = 100 + s;
        else if (s < 25) n = 200 + s - 15;
        else if (s < 38) n = 220 + s - 25;
        else if (s < 42) n = 300 + s - 38;
        else if (s < 45) n = 500 + s - 42;
        else if (s < 48) n = 1000 + s - 45;
        else if (s < 58) n = 2000 + s - 48;
        else if (s < 68) n = 3000 + s - 58;
        else if (s < 78) n = 4000 + s - 68;
        else             n = 5000 + s - 78;
        return n[NUM_W-1:0];
    endfunction

    function automatic void push_beat(input logic [CC_W-1:0] num, input logic [CC_W-1:0] val,
                                      input logic last);
        cc_beat_t b;
        b.num  = num;
        b.val  = val;
        b.chan = chan_now;
        b.last = last;
        cc_expected.push_back(b);
    endfunction

    // Expected control changes for one accepted item; updates the slot cache
    function automatic void encode_nrpn(input nrpn_item_t it);
        int  s;
        bit  emit;
        s = slot_of_number(it.number);
        emit = 1'b0;
        if (it.cmd == CMD_RECV)
        begin
            if (s >= 0)
            begin
                slot_full[s]  = 1'b1;
                slot_value[s] = it.value;
            end
        end
        else if (!it.busy)
        begin
            if (s < 0)
                emit = 1'b1;
            else if (!(slot_full[s] && slot_value[s] == it.value))
            begin
                slot_full[s]  = 1'b1;
                slot_value[s] = it.value;
                emit = 1'b1;
            end
        end
        if (emit)
        begin
            push_beat(CC_NUM_MSB, it.number[13:7], 1'b0);
            push_beat(CC_NUM_LSB, it.number[6:0], 1'b0);
            push_beat(CC_VAL_MSB, it.value[13:7], 1'b0);
            push_beat(CC_VAL_LSB, it.value[6:0], 1'b1);
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("[%0d] error: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    // Input driver: one item per beat, random gap after each accepted beat
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                encode_nrpn(in_item);
                in_gap = $urandom_range(0, in_gap_max);
            end
            if (!(in_valid && in_stall))
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (nrpn_pending.size() != 0)
                begin
                    in_item = nrpn_pending.pop_front();
                    cmd          <= in_item.cmd;
                    param_number <= in_item.number;
                    param_value  <= in_item.value;
                    sysex_busy   <= in_item.busy;
                    in_valid     <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each accepted beat, then stalls a random while
    always @(posedge clk)
    begin
        cc_beat_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (cc_expected.size() == 0)
                    report_mismatch($sformatf("unexpected beat cc %0d value %0d",
                                              cc_number, cc_value));
                else
                begin
                    want = cc_expected.pop_front();
                    if (cc_number !== want.num)
                        report_mismatch($sformatf("cc_number got %0d want %0d",
                                                  cc_number, want.num));
                    if (cc_value !== want.val)
                        report_mismatch($sformatf("cc_value got %0d want %0d (cc %0d)",
                                                  cc_value, want.val, want.num));
                    if (channel !== want.chan)
                        report_mismatch($sformatf("channel got %0d want %0d",
                                                  channel, want.chan));
                    if (last_of_run !== want.last)
                        report_mismatch($sformatf("last_of_run got %0b want %0b (cc %0d)",
                                                  last_of_run, want.last, want.num));
                end
                out_hold = $urandom_range(0, out_stall_max);
            end
            if (out_hold > 0)
            begin
                out_hold--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic add_item(input logic c, input int n, input int v, input logic b);
        nrpn_item_t it;
        it.cmd    = c;
        it.number = n[NUM_W-1:0];
        it.value  = v[NUM_W-1:0];
        it.busy   = b;
        nrpn_pending.push_back(it);
    endtask

    // Wait for all beats out, then for a dropped item to finish its table read
    task automatic wait_drained();
        while (nrpn_pending.size() != 0 || in_valid || cc_expected.size() != 0)
            @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic set_channel(input logic [CHAN_W-1:0] ch);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= ch;
        @(posedge clk);
        cfg_we    <= 1'b0;
        chan_now = ch;
    endtask

    function automatic nrpn_item_t random_item();
        nrpn_item_t it;
        int         pick;
        pick    = $urandom_range(0, 9);
        it.cmd  = ($urandom_range(0, 3) == 0) ? CMD_RECV : CMD_SEND;
        it.busy = ($urandom_range(0, 6) == 0);
        if (pick < 4)
            it.number = number_of_slot($urandom_range(0, SLOTS - 1));
        else if (pick < 7)
            it.number = number_of_slot($urandom_range(0, 5) * 17);
        else
            it.number = NUM_W'($urandom_range(0, 16383));
        case ($urandom_range(0, 3))
            0, 1:    it.value = NUM_W'($urandom_range(0, 3));
            2:       it.value = NUM_W'($urandom_range(0, 16383));
            default: it.value = $urandom_range(0, 1) ? 14'h3FFF : 14'h0000;
        endcase
        return it;
    endfunction

    // One config setting followed by a burst of random traffic
    task automatic run_phase(input logic [CHAN_W-1:0] ch, input int gap_max,
                             input int stall_max, input int count);
        nrpn_item_t it;
        int         n;
        set_channel(ch);
        in_gap_max    = gap_max;
        out_stall_max = stall_max;
        n = 0;
        while (n < count)
        begin
            it = random_item();
            nrpn_pending.push_back(it);
            n++;
            // follow-up to the same slot: exercises dedup and cache-only updates
            if ($urandom_range(0, 3) == 0)
            begin
                it.cmd  = $urandom_range(0, 1) ? CMD_RECV : CMD_SEND;
                it.busy = 1'b0;
                nrpn_pending.push_back(it);
                n++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: edges of ranges and fields, dedup, busy, cache-only updates
        in_gap_max    = 3;
        out_stall_max = 3;
        add_item(CMD_SEND, 100, 0, 1'b0);       // empty slot always emits
        add_item(CMD_SEND, 100, 0, 1'b0);       // same value, suppressed
        add_item(CMD_SEND, 100, 16383, 1'b0);
        add_item(CMD_SEND, 5009, 16383, 1'b0);  // last slot
        add_item(CMD_SEND, 16383, 16383, 1'b0); // unmapped emits every time
        add_item(CMD_SEND, 16383, 16383, 1'b0);
        add_item(CMD_SEND, 0, 0, 1'b0);
        add_item(CMD_SEND, 114, 5, 1'b1);       // busy send dropped
        add_item(CMD_SEND, 114, 5, 1'b0);
        add_item(CMD_RECV, 200, 77, 1'b1);      // recv updates even when busy
        add_item(CMD_SEND, 200, 77, 1'b0);
        add_item(CMD_SEND, 200, 78, 1'b0);
        add_item(CMD_RECV, 7000, 1, 1'b0);      // unmapped recv does nothing
        add_item(CMD_SEND, 99, 1, 1'b0);
        add_item(CMD_SEND, 115, 2, 1'b0);
        add_item(CMD_SEND, 232, 3, 1'b0);
        add_item(CMD_SEND, 233, 3, 1'b0);
        add_item(CMD_SEND, 1002, 14'h2AAA, 1'b0);
        add_item(CMD_SEND, 2010, 14'h1555, 1'b0);
        add_item(CMD_SEND, 3009, 42, 1'b0);
        add_item(CMD_SEND, 4000, 42, 1'b0);
        add_item(CMD_SEND, 5010, 9, 1'b0);
        add_item(CMD_RECV, 5009, 0, 1'b0);
        add_item(CMD_SEND, 5009, 0, 1'b0);
        add_item(CMD_SEND, 5009, 16383, 1'b1);
        wait_drained();

        // Random traffic over several channel settings and idle patterns
        run_phase(5'd16, MAX_IDLE, MAX_IDLE, 31);
        run_phase(5'd0, 0, 0, 31);
        run_phase(5'd31, MAX_IDLE, 0, 31);
        run_phase(5'd17, 0, MAX_IDLE, 31);
        run_phase(5'd1, MAX_IDLE, MAX_IDLE, 31);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
